### rtl/core/ntt_twiddle_factor_generator_defines.svh
// ----------------------------------------------------------------------------
// NTT twiddle factor generator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NTT_TWIDDLE_FACTOR_GENERATOR_DEFINES_SVH
`define NTT_TWIDDLE_FACTOR_GENERATOR_DEFINES_SVH

// Same-cycle implication
`define TFG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ntt_tfg_pkg.sv
// ----------------------------------------------------------------------------
// NTT twiddle factor generator: shared package
// Widths, register indexes, control word types and the step program.
// ----------------------------------------------------------------------------
package ntt_tfg_pkg;

  localparam int POLY_DEGREE_DEF = 256;

  localparam int DATA_W      = 16;
  localparam int IDX_W       = 7;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int RED_BITS    = 4;
  localparam int RED_CYC     = DATA_W / RED_BITS;
  localparam int RED_CNT_W   = $clog2(RED_CYC);
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 2 * DATA_W;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT    = 1'b1;
  localparam logic [DATA_W-1:0]    MODULUS_RST = 16'd3329;
  localparam logic [DATA_W-1:0]    ROOT_RST    = 16'd17;

  // Program addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] STEP_LOAD = 3'd0;
  localparam logic [PC_W-1:0] STEP_TEST = 3'd1;
  localparam logic [PC_W-1:0] STEP_MUL  = 3'd2;
  localparam logic [PC_W-1:0] STEP_SQR  = 3'd3;
  localparam logic [PC_W-1:0] STEP_LOOP = 3'd4;
  localparam logic [PC_W-1:0] STEP_GSQ  = 3'd5;
  localparam logic [PC_W-1:0] STEP_GMUL = 3'd6;
  localparam logic [PC_W-1:0] STEP_FIN  = 3'd7;

  typedef enum logic [2:0] {
    SRC_ONE, SRC_ROOT_RAW, SRC_ACC, SRC_PW, SRC_RT, SRC_GAM
  } src_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_PW_RT, DST_ACC, DST_PW, DST_GAM
  } dst_t;

  typedef enum logic [1:0] {
    JMP_NONE, JMP_BIT_CLR, JMP_CNT_NZ
  } jmp_t;

  // One control word of the step program
  typedef struct packed {
    logic            mul_en;
    src_t            a_sel;
    src_t            b_sel;
    dst_t            dst;
    logic            shift;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
    logic            fin;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic issue;
    logic wb;
    src_t a_sel;
    src_t b_sel;
    dst_t dst;
    logic shift;
  } dp_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic exp_bit;
    logic cnt_nz;
    logic mul_done;
  } dp_stat_t;

  // Step program: right-to-left square-and-multiply for zeta, then
  // gamma = zeta * zeta * root
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w        = '0;
    w.a_sel  = SRC_ONE;
    w.b_sel  = SRC_ONE;
    w.dst    = DST_NONE;
    w.jmp    = JMP_NONE;
    w.target = STEP_LOAD;
    case (pc)
      STEP_LOAD: begin
        w.mul_en = 1'b1;
        w.a_sel  = SRC_ROOT_RAW;
        w.dst    = DST_PW_RT;
      end
      STEP_TEST: begin
        w.jmp    = JMP_BIT_CLR;
        w.target = STEP_SQR;
      end
      STEP_MUL: begin
        w.mul_en = 1'b1;
        w.a_sel  = SRC_ACC;
        w.b_sel  = SRC_PW;
        w.dst    = DST_ACC;
      end
      STEP_SQR: begin
        w.mul_en = 1'b1;
        w.a_sel  = SRC_PW;
        w.b_sel  = SRC_PW;
        w.dst    = DST_PW;
        w.shift  = 1'b1;
      end
      STEP_LOOP: begin
        w.jmp    = JMP_CNT_NZ;
        w.target = STEP_TEST;
      end
      STEP_GSQ: begin
        w.mul_en = 1'b1;
        w.a_sel  = SRC_ACC;
        w.b_sel  = SRC_ACC;
        w.dst    = DST_GAM;
      end
      STEP_GMUL: begin
        w.mul_en = 1'b1;
        w.a_sel  = SRC_GAM;
        w.b_sel  = SRC_RT;
        w.dst    = DST_GAM;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/ntt_tfg_mulmod.sv
// ----------------------------------------------------------------------------
// NTT twiddle factor generator: modular multiplier
// One 16x16 product, then restoring reduction by q, four bits a cycle.
// ----------------------------------------------------------------------------
`include "ntt_twiddle_factor_generator_defines.svh"

module ntt_tfg_mulmod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [ntt_tfg_pkg::DATA_W-1:0] a,
  input  logic [ntt_tfg_pkg::DATA_W-1:0] b,
  input  logic [ntt_tfg_pkg::DATA_W-1:0] q,
  output logic                          done,
  output logic [ntt_tfg_pkg::DATA_W-1:0] res
);
  import ntt_tfg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [RED_CNT_W-1:0] step_r, step_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    low_r, low_nxt;
  logic [PROD_W-1:0]    prod;

  // Shift in bits one by one, subtracting q whenever the partial reaches it
  function automatic logic [DATA_W-1:0] red_digit(input logic [DATA_W-1:0]   rem,
                                                  input logic [RED_BITS-1:0] bits,
                                                  input logic [DATA_W-1:0]   qv);
    logic [DATA_W:0]   t;
    logic [DATA_W-1:0] r;
    r = rem;
    for (int k = RED_BITS - 1; k >= 0; k--) begin
      t = {r, bits[k]};
      if (t >= {1'b0, qv}) begin
        t = t - {1'b0, qv};
      end
      r = t[DATA_W-1:0];
    end
    return r;
  endfunction

  assign prod = PROD_W'(a) * PROD_W'(b);

  // Operands below q keep the upper half of the product below q
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    if (go) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = prod[PROD_W-1:DATA_W];
      low_nxt  = prod[DATA_W-1:0];
    end else if (busy_r) begin
      rem_nxt  = red_digit(rem_r, low_r[DATA_W-1 -: RED_BITS], q);
      low_nxt  = low_r << RED_BITS;
      step_nxt = step_r + RED_CNT_W'(1);
      if (step_r == RED_CNT_W'(RED_CYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
  end

  assign done = done_r;
  assign res  = rem_r;

  `TFG_ASSERT_IMPL(a_go_when_free, go, !busy_r, "product issued while reduction busy")
  `TFG_ASSERT_IMPL(a_done_after_busy, done_r, $past(busy_r) && !busy_r,
                   "done without a finished reduction")

endmodule

### rtl/core/ntt_tfg_datapath.sv
// ----------------------------------------------------------------------------
// NTT twiddle factor generator: datapath
// Exponent shifter, power and accumulator registers, shared multiplier.
// ----------------------------------------------------------------------------
module ntt_tfg_datapath #(
  parameter int POLY_DEGREE = ntt_tfg_pkg::POLY_DEGREE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ntt_tfg_pkg::IDX_W-1:0]  index,
  input  logic [ntt_tfg_pkg::DATA_W-1:0] modulus,
  input  logic [ntt_tfg_pkg::DATA_W-1:0] root,
  input  ntt_tfg_pkg::dp_ctrl_t          ctrl,
  output ntt_tfg_pkg::dp_stat_t          stat,
  output logic [ntt_tfg_pkg::DATA_W-1:0] zeta,
  output logic [ntt_tfg_pkg::DATA_W-1:0] gamma
);
  import ntt_tfg_pkg::*;

  // Exponent width: floor(log2(POLY_DEGREE/2))
  localparam int REV_W = $clog2(POLY_DEGREE / 2 + 1) - 1;
  localparam int CNT_W = $clog2(REV_W + 1);

  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] pw_r, pw_nxt;
  logic [DATA_W-1:0] rt_r, rt_nxt;
  logic [DATA_W-1:0] gam_r, gam_nxt;
  logic [REV_W-1:0]  exp_r, exp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [REV_W-1:0]  rev;
  logic [DATA_W-1:0] op_a, op_b;
  logic              mul_done;
  logic [DATA_W-1:0] mul_res;

  function automatic logic [DATA_W-1:0] pick(input src_t sel,
                                             input logic [DATA_W-1:0] rr,
                                             input logic [DATA_W-1:0] ac,
                                             input logic [DATA_W-1:0] pw,
                                             input logic [DATA_W-1:0] rt,
                                             input logic [DATA_W-1:0] gm);
    logic [DATA_W-1:0] v;
    case (sel)
      SRC_ROOT_RAW: v = rr;
      SRC_ACC:      v = ac;
      SRC_PW:       v = pw;
      SRC_RT:       v = rt;
      SRC_GAM:      v = gm;
      default:      v = DATA_W'(1);
    endcase
    return v;
  endfunction

  // Reverse the low exponent bits of the index
  always_comb begin
    for (int k = 0; k < REV_W; k++) begin
      rev[REV_W-1-k] = index[k];
    end
  end

  assign op_a = pick(ctrl.a_sel, root, acc_r, pw_r, rt_r, gam_r);
  assign op_b = pick(ctrl.b_sel, root, acc_r, pw_r, rt_r, gam_r);

  ntt_tfg_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (ctrl.issue),
    .a     (op_a),
    .b     (op_b),
    .q     (modulus),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Load on a new request, write back products, step the exponent
  always_comb begin
    acc_nxt = acc_r;
    pw_nxt  = pw_r;
    rt_nxt  = rt_r;
    gam_nxt = gam_r;
    exp_nxt = exp_r;
    cnt_nxt = cnt_r;
    if (start) begin
      acc_nxt = (modulus == DATA_W'(1)) ? '0 : DATA_W'(1);
      exp_nxt = rev;
      cnt_nxt = CNT_W'(REV_W);
    end else if (ctrl.wb) begin
      case (ctrl.dst)
        DST_PW_RT: begin
          pw_nxt = mul_res;
          rt_nxt = mul_res;
        end
        DST_ACC: acc_nxt = mul_res;
        DST_PW:  pw_nxt  = mul_res;
        DST_GAM: gam_nxt = mul_res;
        default: ;
      endcase
      if (ctrl.shift) begin
        exp_nxt = exp_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    pw_r  <= pw_nxt;
    rt_r  <= rt_nxt;
    gam_r <= gam_nxt;
    exp_r <= exp_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.exp_bit  = exp_r[0];
  assign stat.cnt_nz   = (cnt_r != '0);
  assign stat.mul_done = mul_done;

  // A zero modulus gives zero results
  assign zeta  = (modulus == '0) ? '0 : acc_r;
  assign gamma = (modulus == '0) ? '0 : gam_r;

endmodule

### rtl/core/ntt_tfg_seq.sv
// ----------------------------------------------------------------------------
// NTT twiddle factor generator: step sequencer
// Step counter over the program table, with conditional jumps.
// ----------------------------------------------------------------------------
`include "ntt_twiddle_factor_generator_defines.svh"

module ntt_tfg_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  out_free,
  input  ntt_tfg_pkg::dp_stat_t stat,
  output ntt_tfg_pkg::dp_ctrl_t ctrl,
  output logic                  idle,
  output logic                  fin
);
  import ntt_tfg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          uw;

  assign uw = ucode(pc_r);

  // Decode the current step, issue products and resolve jumps
  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    fin        = 1'b0;
    ctrl       = '0;
    ctrl.a_sel = uw.a_sel;
    ctrl.b_sel = uw.b_sel;
    ctrl.dst   = uw.dst;
    ctrl.shift = uw.shift;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
          pc_nxt    = STEP_LOAD;
        end
      end
      ST_EXEC: begin
        if (uw.fin) begin
          if (out_free) begin
            fin       = 1'b1;
            state_nxt = ST_IDLE;
            pc_nxt    = STEP_LOAD;
          end
        end else if (uw.mul_en) begin
          ctrl.issue = 1'b1;
          state_nxt  = ST_WAIT;
        end else begin
          case (uw.jmp)
            JMP_BIT_CLR: pc_nxt = !stat.exp_bit ? uw.target : pc_r + PC_W'(1);
            JMP_CNT_NZ:  pc_nxt = stat.cnt_nz ? uw.target : pc_r + PC_W'(1);
            default:     pc_nxt = pc_r + PC_W'(1);
          endcase
        end
      end
      ST_WAIT: begin
        if (stat.mul_done) begin
          ctrl.wb   = 1'b1;
          pc_nxt    = pc_r + PC_W'(1);
          state_nxt = ST_EXEC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= STEP_LOAD;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign idle = (state_r == ST_IDLE);

  `TFG_ASSERT_IMPL(a_start_idle, start, state_r == ST_IDLE, "request taken while busy")
  `TFG_ASSERT_NEXT(a_fin_rewind, fin, state_r == ST_IDLE && pc_r == STEP_LOAD,
                   "program not rewound after result")
  `TFG_ASSERT_IMPL(a_done_waited, stat.mul_done, state_r == ST_WAIT,
                   "product finished with nobody waiting")

endmodule

### rtl/core/ntt_twiddle_factor_generator.sv
// Requests: taken one at a time, only once the previous result has moved to the
//   output register, which waits for the sink; r is the bit-reversed index, its
//   low floor(log2(POLY_DEGREE/2)) bits. Each modular product goes through the
//   shared multiplier and its four-bit-a-cycle reduction.
// Reset: synchronous, active low; modulus 3329, root 17, no result pending.
// ----------------------------------------------------------------------------
// NTT twiddle factor generator
// Returns zeta = root^r and gamma = root^(2r+1) modulo q for a table index.
// ----------------------------------------------------------------------------
`include "ntt_twiddle_factor_generator_defines.svh"

module ntt_twiddle_factor_generator #(
  parameter int POLY_DEGREE = ntt_tfg_pkg::POLY_DEGREE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ntt_tfg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ntt_tfg_pkg::DATA_W-1:0]      cfg_data,
  // Requests
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ntt_tfg_pkg::IN_TDATA_W-1:0]  in_tdata,   // [6:0] index, [7] zero
  // Results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ntt_tfg_pkg::OUT_TDATA_W-1:0] out_tdata   // [15:0] zeta, [31:16] gamma
);
  import ntt_tfg_pkg::*;

  logic [DATA_W-1:0]      modulus_r, root_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   start, out_free, seq_idle, seq_fin;
  dp_ctrl_t               dp_ctrl;
  dp_stat_t               dp_stat;
  logic [DATA_W-1:0]      zeta, gamma;

  // Hold the configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
      root_r    <= ROOT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS: modulus_r <= cfg_data;
        REG_ROOT:    root_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = seq_idle;
  assign start     = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  ntt_tfg_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .stat     (dp_stat),
    .ctrl     (dp_ctrl),
    .idle     (seq_idle),
    .fin      (seq_fin)
  );

  ntt_tfg_datapath #(
    .POLY_DEGREE (POLY_DEGREE)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .index   (in_tdata[IDX_W-1:0]),
    .modulus (modulus_r),
    .root    (root_r),
    .ctrl    (dp_ctrl),
    .stat    (dp_stat),
    .zeta    (zeta),
    .gamma   (gamma)
  );

  // Hold the finished result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_fin) begin
      out_data_r <= {gamma, zeta};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TFG_ASSERT_NEXT(a_busy_after_req, start, !in_tready, "second request taken while busy")

endmodule

### verif/ntt_twiddle_factor_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NTT twiddle factor generator: stand-alone test
// Streams table indexes into the generator under several modulus and root
// settings, predicts zeta and gamma for every request by square-and-multiply,
// and compares each result field by field. Both stream sides idle in random
// bursts, and the result side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module ntt_twiddle_factor_generator_test;
  import ntt_tfg_pkg::*;

  localparam int POLY_DEG      = POLY_DEGREE_DEF;
  localparam int REV_BITS      = $clog2(POLY_DEG / 2);
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 200;
  localparam int NUM_PHASES    = 13;
  localparam int PHASE_ITEMS   = 150;

  // Expected result, gamma in the upper half as on out_tdata
  typedef struct packed {
    logic [DATA_W-1:0] gamma;
    logic [DATA_W-1:0] zeta;
  } twiddle_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_MODULUS;
  logic [DATA_W-1:0]      cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [6:0] index, [7] zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [15:0] zeta, [31:16] gamma

  // Shadow copy of the generator's registers
  logic [DATA_W-1:0] modulus_shadow = MODULUS_RST;
  logic [DATA_W-1:0] root_shadow    = ROOT_RST;

  twiddle_t    pending_twiddles[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          hold_pending = 1'b0;

  ntt_twiddle_factor_generator #(
    .POLY_DEGREE(POLY_DEG)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Right-to-left square-and-multiply; a zero modulus gives zero
  function automatic logic [DATA_W-1:0] mod_power(input logic [DATA_W-1:0] base,
                                                  input int unsigned expo,
                                                  input logic [DATA_W-1:0] q);
    logic [63:0] acc;
    logic [63:0] sq;
    int unsigned e;
    if (q == '0) return '0;
    acc = 64'd1 % q;
    sq  = base % q;
    e   = expo;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % q;
      sq = (sq * sq) % q;
      e  = e >> 1;
    end
    return acc[DATA_W-1:0];
  endfunction

  // Reverse the low index bits to get the exponent, then raise the root
  function automatic twiddle_t predict_twiddles(input logic [IDX_W-1:0] idx);
    twiddle_t    res;
    int unsigned expo;
    expo = 0;
    for (int k = 0; k < REV_BITS; k++) expo = (expo << 1) | idx[k];
    res.zeta  = mod_power(root_shadow, expo, modulus_shadow);
    res.gamma = mod_power(root_shadow, 2 * expo + 1, modulus_shadow);
    return res;
  endfunction

  // Offer one request, after an optional random gap; valid stays high on return
  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - IDX_W){1'b0}}, idx};
    do @(posedge clk); while (!in_tready);
    pending_twiddles.push_back(predict_twiddles(idx));
  endtask

  // Drop valid and let every outstanding result arrive
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (pending_twiddles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write modulus then root back to back, with the block idle
  task automatic load_setting(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] rt);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_MODULUS;
    cfg_data  <= q;
    do @(posedge clk); while (!cfg_ready);
    modulus_shadow = q;
    cfg_index <= REG_ROOT;
    cfg_data  <= rt;
    do @(posedge clk); while (!cfg_ready);
    root_shadow = rt;
    cfg_valid <= 1'b0;
  endtask

  // Reset values: index extremes, single set bits, alternating and block bit patterns
  task automatic test_reset_defaults();
    send_index(7'd0);
    send_index(7'd127);
    send_index(7'd1);
    send_index(7'd64);
    send_index(7'h55);
    send_index(7'h2A);
    send_index(7'h0F);
  endtask

  // Zero modulus, modulus of one, root not below modulus, composite moduli, zero root
  task automatic test_degenerate_moduli();
    logic [DATA_W-1:0] q_list[5]  = '{16'd0, 16'd1, 16'd2, 16'd65535, 16'd15};
    logic [DATA_W-1:0] rt_list[5] = '{16'd17, 16'd3, 16'd65535, 16'd65534, 16'd0};
    for (int s = 0; s < 5; s++) begin
      load_setting(q_list[s], rt_list[s]);
      send_index(7'd0);
      send_index(7'd127);
      send_index(IDX_W'($urandom_range(0, 127)));
    end
  endtask

  // Hold the result side off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    load_setting(MODULUS_RST, ROOT_RST);
    hold_pending = 1'b1;
    for (int n = 0; n < 5; n++) send_index(IDX_W'($urandom_range(0, 127)));
  endtask

  // Random indexes over many settings; no idling in the last phase
  task automatic test_random_settings();
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] rt;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 2))
            0: begin q = 16'd3329;  rt = 16'd17; end
            1: begin q = 16'd7681;  rt = 16'd62; end
            default: begin q = 16'd12289; rt = 16'd11; end
          endcase
        end
        1: begin
          q  = DATA_W'($urandom_range(0, 16));
          rt = DATA_W'($urandom_range(0, 65535));
        end
        default: begin
          q  = DATA_W'($urandom_range(0, 65535));
          rt = DATA_W'($urandom_range(0, 65535));
        end
      endcase
      load_setting(q, rt);
      if (ph == NUM_PHASES - 1) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_index(IDX_W'($urandom_range(0, 127)));
    end
  endtask

  // Result side: long hold-off on request, otherwise random stall bursts
  initial begin : result_sink
    int gap;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    twiddle_t want;
    twiddle_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_twiddles.size() == 0) begin
        $error("result with no request pending: zeta %0d gamma %0d", got.zeta, got.gamma);
        fail_count++;
      end else begin
        want = pending_twiddles.pop_front();
        if (got.zeta !== want.zeta) begin
          $error("zeta mismatch: expected %0d, actual %0d", want.zeta, got.zeta);
          fail_count++;
        end
        if (got.gamma !== want.gamma) begin
          $error("gamma mismatch: expected %0d, actual %0d", want.gamma, got.gamma);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : run_tests
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_degenerate_moduli();
    test_output_backpressure();
    test_random_settings();
    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_twiddles.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### ntt_twiddle_factor_generator.f
+incdir+rtl/core
rtl/core/ntt_tfg_pkg.sv
rtl/core/ntt_tfg_mulmod.sv
rtl/core/ntt_tfg_datapath.sv
rtl/core/ntt_tfg_seq.sv
rtl/core/ntt_twiddle_factor_generator.sv
verif/ntt_twiddle_factor_generator_test.sv
